[rtl/core/gesr_pkg.sv]
// Shared types, constants and helper functions for the graph edge store.
// No dependencies; imported by graph_edge_store_reachability_unit.
package gesr_pkg;

    // Graph size and field widths.
    localparam int MAX_NODES = 32;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = 6;
    localparam int MODE_W    = 3;

    // Operation codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TEST      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REACH     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_COMP  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR_ALL = 3'd5;

    typedef logic [MAX_NODES-1:0] t_nodes;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_in_item;

    typedef struct packed {
        logic answer;
        logic graph_empty;
        logic status;
    } t_out_item;

    // Mask with one bit set for each node index below the given count.
    function automatic t_nodes node_mask(input logic [CNT_W-1:0] count);
        t_nodes m;
        m = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
            if (CNT_W'(i) < count) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    // Index of the lowest set bit; zero when no bit is set.
    function automatic logic [NODE_W-1:0] lowest_index(input t_nodes x);
        t_nodes             one_hot;
        logic [NODE_W-1:0]  idx;
        one_hot = x & (~x + t_nodes'(1));
        idx     = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
            if (one_hot[i]) begin
                idx = idx | NODE_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[rtl/core/graph_edge_store_reachability_unit.sv]
// Directed graph edge store with reachability search over a bit-matrix memory.
// Depends on gesr_pkg for item types, mode codes and mask helpers.
//
// Usage: the input channel (i_in_valid, i_in_item, o_in_stall) carries one
// operation per item: insert, delete or test an edge, ask whether node_b is
// reachable from node_a, delete the component of node_a, or clear all edges.
// Each item returns exactly one result item on the output channel
// (o_out_valid, o_out_item, i_out_stall) holding answer, graph_empty, status.
// The node count register is written through i_cfg_we / i_cfg_wdata; the user
// must do so only while idle; the block does not enforce this. One item is
// worked on at a time; o_in_stall is high until its result has been loaded
// into the output register. Clear-all, unused modes and out-of-range items go
// to the finish state; insert, delete and test pass the edge state; searches
// step through the search state for the row of node_a and each node reached
// (at most the effective node count), reading one adjacency row per cycle
// from a single-port row memory. Reset clears all edges at once through
// per-row valid bits (no clearing pass) and sets the node count to 32. While
// the receiver stalls, the result stays in the output register and the next
// item may already be accepted; its result waits until the register is free.
module graph_edge_store_reachability_unit
    import gesr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    input  t_in_item         i_in_item,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EDGE = 2'd1;
    localparam logic [1:0] ST_SRCH = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]        r_state;
    logic [CNT_W-1:0]  r_num_nodes;
    logic [MODE_W-1:0] r_mode;
    logic [NODE_W-1:0] r_a;
    logic [NODE_W-1:0] r_b;
    logic              r_status;
    logic              r_answer;
    t_nodes            r_vmask;
    t_nodes            r_vis;
    t_nodes            r_pend;
    logic              r_first;
    t_nodes            r_row_valid;
    t_nodes            r_row_nz;
    t_nodes            r_rd_data;
    logic              r_rd_ok;
    logic              r_out_valid;
    t_out_item         r_out_item;

    t_nodes            mem [MAX_NODES];

    logic              in_acc;
    logic [CNT_W-1:0]  n_eff;
    logic              a_bad;
    logic              b_bad;
    logic              n_status;
    logic              rd_en;
    logic [NODE_W-1:0] rd_addr;
    logic              wr_en;
    t_nodes            wr_data;
    t_nodes            row;
    t_nodes            reach;
    t_nodes            n_vis;
    t_nodes            n_pend;
    logic [NODE_W-1:0] next_node;
    t_nodes            next_bit;
    t_nodes            bit_b;
    t_nodes            bit_a;
    logic              out_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // Effective node count and range check of the incoming item.
    assign n_eff = (r_num_nodes > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : r_num_nodes;
    assign a_bad = ({1'b0, i_in_item.node_a} >= n_eff);
    assign b_bad = ({1'b0, i_in_item.node_b} >= n_eff);

    always_comb begin
        case (i_in_item.mode)
            MODE_INSERT, MODE_DELETE, MODE_TEST, MODE_REACH: n_status = a_bad || b_bad;
            MODE_DEL_COMP: n_status = a_bad;
            default: n_status = 1'b0;
        endcase
    end

    // Row read from memory; a row that was never written since a clear reads as empty.
    assign row   = r_rd_ok ? r_rd_data : '0;
    assign bit_b = t_nodes'(1) << r_b;
    assign bit_a = t_nodes'(1) << r_a;

    // Edge update of the addressed row.
    assign wr_data = (r_mode == MODE_INSERT) ? (row | bit_b) : (row & ~bit_b);
    assign wr_en   = (r_state == ST_EDGE) &&
                     ((r_mode == MODE_INSERT) || (r_mode == MODE_DELETE));

    // One search step: merge the successors of the row just read.
    assign reach     = row & r_vmask;
    assign n_vis     = r_first ? reach : (r_vis | reach);
    assign n_pend    = r_first ? reach : (r_pend | (reach & ~r_vis));
    assign next_node = lowest_index(n_pend);
    assign next_bit  = t_nodes'(1) << next_node;

    // Row read port control.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = i_in_item.node_a;
        if (in_acc) begin
            rd_en = 1'b1;
        end else if ((r_state == ST_SRCH) && (n_pend != '0)) begin
            rd_en   = 1'b1;
            rd_addr = next_node;
        end
    end

    // Adjacency row memory.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_a] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Sequencer and graph bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_num_nodes <= CNT_W'(MAX_NODES);
            r_row_valid <= '0;
            r_row_nz    <= '0;
            r_out_valid <= 1'b0;
            r_first     <= 1'b0;
            r_rd_ok     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num_nodes <= i_cfg_wdata;
            end
            if (rd_en) begin
                r_rd_ok <= r_row_valid[rd_addr];
            end

            // Output register drains when the receiver takes the item.
            if ((r_state == ST_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_mode   <= i_in_item.mode;
                        r_a      <= i_in_item.node_a;
                        r_b      <= i_in_item.node_b;
                        r_status <= n_status;
                        r_answer <= 1'b0;
                        r_vmask  <= node_mask(n_eff);
                        r_first  <= 1'b1;
                        if (n_status) begin
                            r_state <= ST_FIN;
                        end else begin
                            case (i_in_item.mode)
                                MODE_INSERT, MODE_DELETE, MODE_TEST: r_state <= ST_EDGE;
                                MODE_REACH, MODE_DEL_COMP:           r_state <= ST_SRCH;
                                MODE_CLEAR_ALL: begin
                                    r_row_valid <= '0;
                                    r_row_nz    <= '0;
                                    r_state     <= ST_FIN;
                                end
                                default: r_state <= ST_FIN;
                            endcase
                        end
                    end
                end
                ST_EDGE: begin
                    if (wr_en) begin
                        r_row_valid[r_a] <= 1'b1;
                        r_row_nz[r_a]    <= |wr_data;
                    end
                    if (r_mode == MODE_TEST) begin
                        r_answer <= row[r_b];
                    end
                    r_state <= ST_FIN;
                end
                ST_SRCH: begin
                    r_first <= 1'b0;
                    r_vis   <= n_vis;
                    r_pend  <= n_pend & ~next_bit;
                    if (n_pend == '0) begin
                        // Search closed: answer the query or drop the component.
                        if (r_mode == MODE_REACH) begin
                            r_answer <= n_vis[r_b];
                        end else begin
                            r_row_valid <= r_row_valid & ~(n_vis | bit_a);
                            r_row_nz    <= r_row_nz & ~(n_vis | bit_a);
                        end
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_out_item.answer      <= r_answer;
                        r_out_item.graph_empty <= (r_row_nz == '0);
                        r_out_item.status      <= r_status;
                        r_state                <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

[tb/tb_graph_edge_store_reachability_unit.sv]
// Testbench for graph_edge_store_reachability_unit: directed and random edge operations,
// reachability queries and node count changes, checked against an untimed graph model.
// Depends on gesr_pkg and the graph_edge_store_reachability_unit RTL.
`timescale 1ns / 100ps

module tb_graph_edge_store_reachability_unit;
    import gesr_pkg::*;

    // Codes that the block accepts but does nothing with.
    localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

    localparam int CYCLE_LIMIT    = 600_000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 140;

    // Graph model: adjacency rows, node count and the queue of expected results.
    class reach_scoreboard;
        typedef struct {
            t_in_item  op;
            t_out_item res;
        } t_pending;

        t_nodes           adj [MAX_NODES];
        logic [CNT_W-1:0] node_count;
        t_pending         expected_q [$];
        int errors;
        int n_items;
        int n_searches;
        int n_reachable;
        int n_comp_deletes;
        int n_rejected;

        function new();
            foreach (adj[i]) adj[i] = '0;
            node_count     = CNT_W'(32);
            errors         = 0;
            n_items        = 0;
            n_searches     = 0;
            n_reachable    = 0;
            n_comp_deletes = 0;
            n_rejected     = 0;
        endfunction

        function void write_count(logic [CNT_W-1:0] value);
            node_count = value;
        endfunction

        // Counts above the matrix size are saturated.
        function int eff_count();
            int c;
            c = node_count;
            return (c > MAX_NODES) ? MAX_NODES : c;
        endfunction

        function t_nodes in_use();
            t_nodes m;
            m = '0;
            for (int i = 0; i < MAX_NODES; i++) begin
                if (i < eff_count()) m[i] = 1'b1;
            end
            return m;
        endfunction

        // Nodes reached from src by a path of one or more edges through nodes in use.
        function t_nodes reach_set(int src);
            t_nodes live;
            t_nodes seen;
            t_nodes wave;
            t_nodes grow;
            live = in_use();
            seen = adj[src] & live;
            wave = seen;
            for (int step = 0; step < MAX_NODES && wave != '0; step++) begin
                grow = '0;
                for (int u = 0; u < MAX_NODES; u++) begin
                    if (wave[u]) grow |= adj[u];
                end
                grow &= live & ~seen;
                seen |= grow;
                wave = grow;
            end
            return seen;
        endfunction

        // Applies one accepted item to the graph and queues its result.
        function void note_item(t_in_item op);
            int        n;
            int        a;
            int        b;
            logic      bad;
            t_nodes    comp;
            t_out_item res;
            t_pending  entry;
            n   = eff_count();
            a   = op.node_a;
            b   = op.node_b;
            res = '0;
            case (op.mode)
                MODE_INSERT, MODE_DELETE, MODE_TEST, MODE_REACH: bad = (a >= n) || (b >= n);
                MODE_DEL_COMP: bad = (a >= n);
                default: bad = 1'b0;
            endcase
            if (bad) begin
                n_rejected++;
            end else begin
                case (op.mode)
                    MODE_INSERT: adj[a][b] = 1'b1;
                    MODE_DELETE: adj[a][b] = 1'b0;
                    MODE_TEST: res.answer = adj[a][b];
                    MODE_REACH: begin
                        comp = reach_set(a);
                        res.answer = comp[b];
                        n_searches++;
                        if (comp[b]) n_reachable++;
                    end
                    MODE_DEL_COMP: begin
                        comp = reach_set(a);
                        comp[a] = 1'b1;
                        for (int u = 0; u < MAX_NODES; u++) begin
                            if (comp[u]) adj[u] = '0;
                        end
                        n_comp_deletes++;
                    end
                    MODE_CLEAR_ALL: foreach (adj[i]) adj[i] = '0;
                    default: ;
                endcase
            end
            res.status      = bad;
            res.graph_empty = 1'b1;
            foreach (adj[i]) begin
                if (adj[i] != '0) res.graph_empty = 1'b0;
            end
            entry.op   = op;
            entry.res  = res;
            expected_q = {expected_q, entry};
            n_items++;
        endfunction

        // Compares one delivered result with the oldest expectation.
        function void check_result(t_out_item got);
            t_pending want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected, actual %b", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.answer !== want.res.answer) begin
                $display("%0t: answer mismatch (mode %0d a %0d b %0d) expected %b actual %b",
                         $time, want.op.mode, want.op.node_a, want.op.node_b,
                         want.res.answer, got.answer);
                errors++;
            end
            if (got.graph_empty !== want.res.graph_empty) begin
                $display("%0t: graph_empty mismatch (mode %0d a %0d b %0d) expected %b actual %b",
                         $time, want.op.mode, want.op.node_a, want.op.node_b,
                         want.res.graph_empty, got.graph_empty);
                errors++;
            end
            if (got.status !== want.res.status) begin
                $display("%0t: status mismatch (mode %0d a %0d b %0d) expected %b actual %b",
                         $time, want.op.mode, want.op.node_a, want.op.node_b,
                         want.res.status, got.status);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;
    logic             in_valid  = 1'b0;
    t_in_item         in_item   = '0;
    logic             in_stall;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_item        out_item;

    reach_scoreboard  sb;
    int               cycle_count = 0;
    int               burst_left  = 0;
    int               count_writes = 0;

    graph_edge_store_reachability_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #10 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver stall: switches between no stall, light, heavy and long held stalls.
    int stall_style = 0;
    int style_left  = 0;
    int hold_left   = 0;
    always @(posedge clk) begin
        if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(50, 300);
        end else begin
            style_left--;
        end
        case (stall_style)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: begin
                if (hold_left == 0) begin
                    out_stall <= ~out_stall;
                    hold_left = $urandom_range(1, 30);
                end else begin
                    hold_left--;
                end
            end
        endcase
    end

    // Result monitor.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
    end

    // Sends one item and waits for the edge that accepts it; a burst ends with a random gap, possibly none.
    task automatic push_item(input t_in_item op);
        int gap;
        in_valid <= 1'b1;
        in_item  <= op;
        do @(posedge clk); while (in_stall);
        sb.note_item(op);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic push_op(input logic [MODE_W-1:0] mode, input int a, input int b);
        t_in_item op;
        op.mode   = mode;
        op.node_a = NODE_W'(a);
        op.node_b = NODE_W'(b);
        push_item(op);
    endtask

    // Waits until every expected result has come back and the block has settled.
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Node count writes happen only with the block idle.
    task automatic set_node_count(input int value);
        drain(4);
        cfg_we    <= 1'b1;
        cfg_wdata <= CNT_W'(value);
        @(posedge clk);
        sb.write_count(CNT_W'(value));
        cfg_we    <= 1'b0;
        count_writes++;
    endtask

    // Mostly in-range nodes, with an occasional index anywhere in the field.
    function automatic logic [NODE_W-1:0] pick_node(input int n);
        if (n > 0 && $urandom_range(0, 9) != 0) return NODE_W'($urandom_range(0, n - 1));
        return NODE_W'($urandom_range(0, MAX_NODES - 1));
    endfunction

    // Random operation; some inserts (half of those from an in-range node) extend a chain so that searches run deep.
    function automatic t_in_item random_op(input int n);
        int       r;
        t_in_item op;
        r         = $urandom_range(0, 99);
        op.node_a = pick_node(n);
        op.node_b = pick_node(n);
        if (r < 36) begin
            op.mode = MODE_INSERT;
            if (n > 0 && op.node_a < n && $urandom_range(0, 1) == 1)
                op.node_b = NODE_W'((op.node_a + 1) % n);
        end else if (r < 48) begin
            op.mode = MODE_DELETE;
        end else if (r < 62) begin
            op.mode = MODE_TEST;
        end else if (r < 85) begin
            op.mode = MODE_REACH;
        end else if (r < 89) begin
            op.mode = MODE_DEL_COMP;
        end else if (r < 90) begin
            op.mode = MODE_CLEAR_ALL;
        end else if (r < 93) begin
            op.mode = ($urandom_range(0, 1) == 1) ? MODE_SPARE6 : MODE_SPARE7;
        end else begin
            op.mode   = MODE_W'($urandom_range(0, 7));
            op.node_a = NODE_W'($urandom_range(0, MAX_NODES - 1));
            op.node_b = NODE_W'($urandom_range(0, MAX_NODES - 1));
        end
        return op;
    endfunction

    int phase_counts [11] = '{7, 32, 1, 16, 0, 45, 2, 32, 24, 63, 32};

    initial begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Empty graph, field extremes and a two-node cycle through the end nodes.
        push_op(MODE_CLEAR_ALL, 31, 31);
        push_op(MODE_TEST, 0, 31);
        push_op(MODE_INSERT, 0, 31);
        push_op(MODE_INSERT, 31, 0);
        push_op(MODE_REACH, 0, 0);
        // A self loop makes a node reachable from itself; a node without one is not.
        push_op(MODE_INSERT, 21, 21);
        push_op(MODE_REACH, 21, 21);
        push_op(MODE_REACH, 10, 10);
        push_op(MODE_INSERT, 10, 21);
        push_op(MODE_INSERT, 0, 10);
        push_op(MODE_REACH, 31, 21);
        // Component deletion keeps the edge coming in from outside.
        push_op(MODE_INSERT, 5, 0);
        push_op(MODE_DEL_COMP, 31, 0);
        push_op(MODE_TEST, 5, 0);
        push_op(MODE_REACH, 31, 0);
        push_op(MODE_SPARE6, 31, 31);
        push_op(MODE_SPARE7, 0, 0);
        push_op(MODE_DELETE, 5, 0);
        push_op(MODE_INSERT, 20, 20);

        // Lowered count: the edge on node 20 stays but is out of reach.
        set_node_count(4);
        push_op(MODE_INSERT, 3, 3);
        push_op(MODE_INSERT, 3, 4);
        push_op(MODE_TEST, 20, 20);
        push_op(MODE_DEL_COMP, 7, 0);
        push_op(MODE_REACH, 3, 3);
        push_op(MODE_CLEAR_ALL, 9, 9);

        // No node in use, then a count above the matrix size.
        set_node_count(0);
        push_op(MODE_INSERT, 0, 0);
        push_op(MODE_DEL_COMP, 0, 0);
        set_node_count(63);
        push_op(MODE_INSERT, 31, 30);
        push_op(MODE_REACH, 31, 30);

        // Random phases, each under its own node count.
        foreach (phase_counts[p]) begin
            set_node_count(phase_counts[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) push_item(random_op(sb.eff_count()));
        end

        drain(SETTLE_CYCLES);
        $display("Ran %0d items under %0d node count settings: %0d reachability queries",
                 sb.n_items, count_writes, sb.n_searches);
        $display("(%0d reachable), %0d component deletions, %0d rejected for node range.",
                 sb.n_reachable, sb.n_comp_deletes, sb.n_rejected);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/gesr_pkg.sv
rtl/core/graph_edge_store_reachability_unit.sv
tb/tb_graph_edge_store_reachability_unit.sv
